[src/tgadec_pkg.sv]
// ---------------------------------------------------------------------------
// tgadec_pkg
// Shared constants, codes and control/status bundles of the Targa decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package tgadec_pkg;

  // Largest pixel the decoder packs, in bytes
  localparam int MAX_PIXEL_BYTES_DEF = 4;

  // Header byte positions
  localparam logic [4:0] HDR_TYPE      = 5'd2;
  localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
  localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
  localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
  localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
  localparam logic [4:0] HDR_DEPTH     = 5'd16;
  localparam logic [4:0] HDR_LAST      = 5'd17;

  // Image type codes
  localparam logic [7:0] TYPE_RAW = 8'd2;
  localparam logic [7:0] TYPE_RLE = 8'd10;

  // Packet head decoding
  localparam logic [8:0] RUN_BIAS = 9'd127;
  localparam logic [7:0] RUN_MAX  = 8'd128;

  typedef enum logic [2:0] {
    ST_WORKING  = 3'd0,
    ST_COMPLETE = 3'd1,
    ST_BAD_TYPE = 3'd2,
    ST_BAD_SIZE = 3'd3,
    ST_OVERRUN  = 3'd4,
    ST_IGNORED  = 3'd5
  } status_t;

  // What the result beat carries
  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_PIXEL,
    OUT_RUN
  } out_kind_t;

  typedef struct packed {
    logic      restart;
    logic      hdr_step;
    logic      hdr_final;
    logic      head_load;
    logic      gather;
    logic      data_pix;
    logic      run_start;
    logic      expand_step;
    logic      emit;
    out_kind_t out_kind;
    status_t   status;
    logic      last;
  } dp_cmd_t;

  typedef struct packed {
    logic hdr_is_type;
    logic type_ok;
    logic hdr_final;
    logic size_bad;
    logic area_zero;
    logic is_rle;
    logic overrun;
    logic head_is_run;
    logic gather_done;
    logic data_left_zero;
    logic packet_end;
    logic run_left_zero;
    logic rem_more;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

[src/tgadec_in_if.sv]
// ---------------------------------------------------------------------------
// tgadec_in_if
// Byte channel into the decoder: one file byte per beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface tgadec_in_if;
  logic       valid;
  logic       ready;
  logic       restart;
  logic [7:0] data_byte;

  modport source (output valid, output restart, output data_byte, input ready);
  modport sink   (input valid, input restart, input data_byte, output ready);
endinterface

`default_nettype wire

[src/tgadec_out_if.sv]
// ---------------------------------------------------------------------------
// tgadec_out_if
// Result channel of the decoder: up to two pixels plus header info per beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface tgadec_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_first;
  logic [31:0] pixel_second;
  logic [1:0]  pixel_count;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic [7:0]  pixel_bits;
  logic [2:0]  status;
  logic        last;

  modport source (
    output valid, output pixel_first, output pixel_second, output pixel_count,
    output image_width, output image_height, output pixel_bits, output status,
    output last, input ready
  );
  modport sink (
    input valid, input pixel_first, input pixel_second, input pixel_count,
    input image_width, input image_height, input pixel_bits, input status,
    input last, output ready
  );
endinterface

`default_nettype wire

[src/tgadec_dp.sv]
// ---------------------------------------------------------------------------
// tgadec_dp
// Decoder datapath: header fields, pixel gathering, packet and run counters,
// and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module tgadec_dp #(
  parameter int MAX_PIXEL_BYTES = tgadec_pkg::MAX_PIXEL_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tgadec_pkg::dp_cmd_t   cmd,
  output tgadec_pkg::dp_stat_t  stat,
  input  logic [7:0]            data_byte,
  tgadec_out_if.source          out_bus
);
  import tgadec_pkg::*;

  localparam logic [4:0] MaxSize = 5'(MAX_PIXEL_BYTES);

  // Header registers
  logic [4:0]  hcount_r, hcount_nxt, hcount_eff;
  logic        is_rle_r, is_rle_nxt;
  logic [15:0] width_r, width_nxt, width_eff;
  logic [15:0] height_r, height_nxt, height_eff;
  logic [7:0]  bits_r, bits_nxt, bits_eff;

  // Image and packet counters
  logic [31:0] pix_left_r, pix_left_nxt;
  logic [7:0]  pkt_left_r, pkt_left_nxt;

  // Pixel gathering
  logic [MAX_PIXEL_BYTES-1:0][7:0] lanes_r, lanes_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [4:0]  size;
  logic [31:0] pix;

  // Run expansion
  logic [31:0] run_pix_r, run_pix_src;
  logic [7:0]  rem_r, rem_src, rem_after, run_n;
  logic [1:0]  chunk_c;

  // Derived values
  logic [8:0]  head_n;
  logic [31:0] pix_left_dec, pix_left_sub;
  logic [7:0]  pkt_dec;

  // Result register
  logic        out_valid_r;
  logic [31:0] out_first_r, out_second_r;
  logic [1:0]  out_count_r;
  logic [15:0] out_width_r, out_height_r;
  logic [7:0]  out_bits_r;
  status_t     out_status_r;
  logic        out_last_r;

  // Header byte capture; a restart byte sees the reset values
  always_comb begin
    hcount_eff = cmd.restart ? 5'd0  : hcount_r;
    width_eff  = cmd.restart ? 16'd0 : width_r;
    height_eff = cmd.restart ? 16'd0 : height_r;
    bits_eff   = cmd.restart ? 8'd0  : bits_r;
    hcount_nxt = hcount_r;
    is_rle_nxt = is_rle_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    bits_nxt   = bits_r;
    if (cmd.hdr_step) begin
      width_nxt  = width_eff;
      height_nxt = height_eff;
      bits_nxt   = bits_eff;
      hcount_nxt = (hcount_eff >= HDR_LAST) ? hcount_eff : hcount_eff + 5'd1;
      case (hcount_eff)
        HDR_TYPE:      is_rle_nxt = (data_byte == TYPE_RLE);
        HDR_WIDTH_LO:  width_nxt  = {width_eff[15:8], data_byte};
        HDR_WIDTH_HI:  width_nxt  = {data_byte, width_eff[7:0]};
        HDR_HEIGHT_LO: height_nxt = {height_eff[15:8], data_byte};
        HDR_HEIGHT_HI: height_nxt = {data_byte, height_eff[7:0]};
        HDR_DEPTH:     bits_nxt   = data_byte;
        default:       ;
      endcase
    end
  end

  // Pixel assembly: earlier lanes of this pixel plus the current byte
  assign size = bits_r[7:3];
  always_comb begin
    pix       = '0;
    lanes_nxt = lanes_r;
    for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
      if (2'(i) < idx_r) begin
        pix[8*i +: 8] = lanes_r[i];
      end else if (2'(i) == idx_r) begin
        pix[8*i +: 8] = data_byte;
        if (cmd.gather) begin
          lanes_nxt[i] = data_byte;
        end
      end
    end
  end

  // Packet head length: literal c+1, run c-127
  assign head_n = data_byte[7] ? ({1'b0, data_byte} - RUN_BIAS) : ({1'b0, data_byte} + 9'd1);

  // Counter updates
  assign pix_left_dec = (pix_left_r == 32'd0) ? 32'd0 : pix_left_r - 32'd1;
  assign pkt_dec      = (pkt_left_r == 8'd0) ? 8'd0 : pkt_left_r - 8'd1;
  assign run_n        = (pkt_left_r > RUN_MAX) ? RUN_MAX : pkt_left_r;
  assign pix_left_sub = (pix_left_r >= {24'd0, run_n}) ? pix_left_r - {24'd0, run_n} : 32'd0;

  // Run chunking: two copies per beat while enough remain
  assign rem_src     = cmd.run_start ? run_n : rem_r;
  assign run_pix_src = cmd.run_start ? pix : run_pix_r;
  assign chunk_c     = (rem_src >= 8'd2) ? 2'd2 : rem_src[1:0];
  assign rem_after   = rem_src - {6'd0, chunk_c};

  always_comb begin
    pix_left_nxt = pix_left_r;
    pkt_left_nxt = pkt_left_r;
    idx_nxt      = idx_r;
    if (cmd.hdr_final) begin
      pix_left_nxt = width_r * height_r;
      idx_nxt      = 2'd0;
    end
    if (cmd.head_load) begin
      pkt_left_nxt = head_n[7:0];
      idx_nxt      = 2'd0;
    end
    if (cmd.gather) begin
      idx_nxt = stat.gather_done ? 2'd0 : idx_r + 2'd1;
    end
    if (cmd.data_pix) begin
      pix_left_nxt = pix_left_dec;
      pkt_left_nxt = pkt_dec;
    end
    if (cmd.run_start) begin
      pix_left_nxt = pix_left_sub;
      pkt_left_nxt = 8'd0;
    end
  end

  // Status toward the controller
  always_comb begin
    stat.hdr_is_type    = (hcount_eff == HDR_TYPE);
    stat.type_ok        = (data_byte == TYPE_RAW) || (data_byte == TYPE_RLE);
    stat.hdr_final      = (hcount_eff >= HDR_LAST);
    stat.size_bad       = (size == 5'd0) || (size > MaxSize);
    stat.area_zero      = (width_r == 16'd0) || (height_r == 16'd0);
    stat.is_rle         = is_rle_r;
    stat.overrun        = (pix_left_r < {23'd0, head_n});
    stat.head_is_run    = data_byte[7];
    stat.gather_done    = (({3'd0, idx_r} + 5'd1) >= size);
    stat.data_left_zero = (pix_left_dec == 32'd0);
    stat.packet_end     = (pkt_dec == 8'd0);
    stat.run_left_zero  = (pix_left_sub == 32'd0);
    stat.rem_more       = (rem_after != 8'd0);
    stat.out_free       = !out_valid_r || out_bus.ready;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hcount_r    <= 5'd0;
      is_rle_r    <= 1'b0;
      width_r     <= 16'd0;
      height_r    <= 16'd0;
      bits_r      <= 8'd0;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      hcount_r <= hcount_nxt;
      is_rle_r <= is_rle_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      bits_r   <= bits_nxt;
      idx_r    <= idx_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pix_left_r <= pix_left_nxt;
    pkt_left_r <= pkt_left_nxt;
    lanes_r    <= lanes_nxt;
    if (cmd.run_start || cmd.expand_step) begin
      rem_r <= rem_after;
    end
    if (cmd.run_start) begin
      run_pix_r <= pix;
    end
    if (cmd.emit) begin
      out_width_r  <= width_nxt;
      out_height_r <= height_nxt;
      out_bits_r   <= bits_nxt;
      out_status_r <= cmd.status;
      out_last_r   <= cmd.last;
      case (cmd.out_kind)
        OUT_PIXEL: begin
          out_first_r  <= pix;
          out_second_r <= 32'd0;
          out_count_r  <= 2'd1;
        end
        OUT_RUN: begin
          out_first_r  <= (chunk_c != 2'd0) ? run_pix_src : 32'd0;
          out_second_r <= (chunk_c == 2'd2) ? run_pix_src : 32'd0;
          out_count_r  <= chunk_c;
        end
        default: begin
          out_first_r  <= 32'd0;
          out_second_r <= 32'd0;
          out_count_r  <= 2'd0;
        end
      endcase
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.pixel_first  = out_first_r;
  assign out_bus.pixel_second = out_second_r;
  assign out_bus.pixel_count  = out_count_r;
  assign out_bus.image_width  = out_width_r;
  assign out_bus.image_height = out_height_r;
  assign out_bus.pixel_bits   = out_bits_r;
  assign out_bus.status       = out_status_r;
  assign out_bus.last         = out_last_r;

endmodule

`default_nettype wire

[src/tgadec_ctrl.sv]
// ---------------------------------------------------------------------------
// tgadec_ctrl
// Decoder controller: parse phase sequencing, input handshake, and the
// run expansion that holds the input while copies go out.
// ---------------------------------------------------------------------------
`default_nettype none

module tgadec_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_restart,
  output logic                 in_ready,
  output tgadec_pkg::dp_cmd_t  cmd,
  input  tgadec_pkg::dp_stat_t stat
);
  import tgadec_pkg::*;

  typedef enum logic [2:0] {
    S_HEADER,
    S_HEAD,
    S_DATA,
    S_RUN,
    S_EXPAND,
    S_DONE,
    S_ERROR
  } state_t;

  state_t state_r, state_nxt, cur;
  logic   done_r, done_nxt;
  logic   accept;

  assign in_ready = stat.out_free && (state_r != S_EXPAND);
  assign accept   = in_valid && in_ready;
  assign cur      = in_restart ? S_HEADER : state_r;

  // Next state and datapath commands
  always_comb begin
    cmd          = '0;
    cmd.out_kind = OUT_NONE;
    cmd.status   = ST_WORKING;
    cmd.last     = 1'b1;
    state_nxt    = state_r;
    done_nxt     = done_r;
    if (accept) begin
      cmd.emit    = 1'b1;
      cmd.restart = in_restart;
      case (cur)
        S_HEADER: begin
          cmd.hdr_step = 1'b1;
          if (stat.hdr_is_type && !stat.type_ok) begin
            state_nxt  = S_ERROR;
            cmd.status = ST_BAD_TYPE;
          end else if (stat.hdr_final) begin
            if (stat.size_bad) begin
              state_nxt  = S_ERROR;
              cmd.status = ST_BAD_SIZE;
            end else begin
              cmd.hdr_final = 1'b1;
              if (stat.area_zero) begin
                state_nxt  = S_DONE;
                cmd.status = ST_COMPLETE;
              end else begin
                state_nxt = stat.is_rle ? S_HEAD : S_DATA;
              end
            end
          end else begin
            state_nxt = S_HEADER;
          end
        end
        S_HEAD: begin
          if (stat.overrun) begin
            state_nxt  = S_ERROR;
            cmd.status = ST_OVERRUN;
          end else begin
            cmd.head_load = 1'b1;
            state_nxt     = stat.head_is_run ? S_RUN : S_DATA;
          end
        end
        S_DATA: begin
          cmd.gather = 1'b1;
          if (stat.gather_done) begin
            cmd.data_pix = 1'b1;
            cmd.out_kind = OUT_PIXEL;
            if (stat.is_rle) begin
              if (stat.packet_end) begin
                state_nxt = stat.data_left_zero ? S_DONE : S_HEAD;
              end
            end else if (stat.data_left_zero) begin
              state_nxt = S_DONE;
            end
            if ((stat.is_rle && stat.packet_end && stat.data_left_zero) ||
                (!stat.is_rle && stat.data_left_zero)) begin
              cmd.status = ST_COMPLETE;
            end
          end
        end
        S_RUN: begin
          cmd.gather = 1'b1;
          if (stat.gather_done) begin
            cmd.run_start = 1'b1;
            cmd.out_kind  = OUT_RUN;
            done_nxt      = stat.run_left_zero;
            if (stat.rem_more) begin
              state_nxt = S_EXPAND;
              cmd.last  = 1'b0;
            end else begin
              state_nxt  = stat.run_left_zero ? S_DONE : S_HEAD;
              cmd.status = stat.run_left_zero ? ST_COMPLETE : ST_WORKING;
            end
          end
        end
        S_DONE:  cmd.status = ST_IGNORED;
        S_ERROR: cmd.status = ST_IGNORED;
        default: cmd.status = ST_IGNORED;
      endcase
    end else if ((state_r == S_EXPAND) && stat.out_free) begin
      // one more beat of copies
      cmd.emit        = 1'b1;
      cmd.expand_step = 1'b1;
      cmd.out_kind    = OUT_RUN;
      if (stat.rem_more) begin
        cmd.last = 1'b0;
      end else begin
        state_nxt  = done_r ? S_DONE : S_HEAD;
        cmd.status = done_r ? ST_COMPLETE : ST_WORKING;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_HEADER;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  // A result beat is only built when the result register can take it
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.out_free)
    else $error("result beat built while result register busy");

  // Expansion is entered only from a run packet
  a_expand_entry: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == S_EXPAND) |-> ($past(state_r) == S_RUN))
    else $error("expansion entered from wrong phase");

  // A new byte and an expansion beat never share a cycle
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(accept && cmd.expand_step))
    else $error("byte taken during run expansion");

  // The final copy beat leaves expansion
  a_expand_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.expand_step && cmd.last) |=> (state_r != S_EXPAND))
    else $error("expansion did not end after last beat");

endmodule

`default_nettype wire

[src/tga_rle_image_decoder.sv]
// A result beat is valid in the cycle after its byte is accepted.
// Throughput: one byte per cycle unless the result channel stalls; a byte
// ending a run pixel of n copies gives ceil(n/2) beats, input held between.
// The single result register limits the rate to one beat per cycle.
// Reset: synchronous, active low; parser returns to header byte 0 with all
// header fields zero. No clearing pass is needed.
// ---------------------------------------------------------------------------
// tga_rle_image_decoder
// Targa truecolor decoder (raw and run-length), fed one file byte per beat.
// ---------------------------------------------------------------------------
`default_nettype none

module tga_rle_image_decoder #(
  parameter int MAX_PIXEL_BYTES = tgadec_pkg::MAX_PIXEL_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  tgadec_in_if.sink    in_bus,
  tgadec_out_if.source out_bus
);
  import tgadec_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;

  assign in_bus.ready = in_ready;

  // Phase sequencing and handshake
  tgadec_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_bus.valid),
    .in_restart (in_bus.restart),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .stat       (stat)
  );

  // Header fields, counters, gathering, result register
  tgadec_dp #(
    .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .data_byte (in_bus.data_byte),
    .out_bus   (out_bus)
  );

endmodule

`default_nettype wire
